[design/spq_pkg.sv]
// Package for the sorted priority queue: sizes, operation and status codes,
// and the command and result structs shared by the front, back and top level.
// No dependencies.
package spq_pkg;

  // Storage size and derived widths
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned STAT_W   = 2;

  // Command queue between front and back (depth is a power of two)
  localparam int unsigned CQ_DEPTH = 2;
  localparam int unsigned CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int unsigned CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Classified command handed from the front to the back
  typedef struct packed {
    func_e                    func;
    logic [DATA_W-1:0]        data;
    logic signed [PRIO_W-1:0] prio;
  } cmd_t;

  // Command queue handshake toward the back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

  // One result item
  typedef struct packed {
    status_e                  status;
    logic [DATA_W-1:0]        removed_data;
    logic signed [PRIO_W-1:0] removed_prio;
    logic                     head_valid;
    logic [DATA_W-1:0]        head_data;
    logic signed [PRIO_W-1:0] head_prio;
    logic [OCC_W-1:0]         occupancy;
  } rsp_t;

endpackage

[design/spq_intf.sv]
// Valid/ready channel bundles for the sorted priority queue: request and response.
// Depends on spq_pkg for the field widths.
interface spq_req_if import spq_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [DATA_W-1:0]        item_data;
  logic signed [PRIO_W-1:0] item_priority;

  modport source (output valid, func, item_data, item_priority, input ready);
  modport sink   (input valid, func, item_data, item_priority, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [DATA_W-1:0]        removed_data;
  logic signed [PRIO_W-1:0] removed_priority;
  logic                     head_valid;
  logic [DATA_W-1:0]        head_data;
  logic signed [PRIO_W-1:0] head_priority;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, status, removed_data, removed_priority, head_valid,
                  head_data, head_priority, occupancy, input ready);
  modport sink   (input valid, status, removed_data, removed_priority, head_valid,
                  head_data, head_priority, occupancy, output ready);
endinterface

[design/spq_front.sv]
// Front end of the sorted priority queue: accepts classified commands from the
// top level and buffers them in a short command queue. Uses spq_pkg.
module spq_front import spq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  cmd_t              req_cmd_i,
  output cmd_chan_t         cq_o,
  input  logic              cq_pop_i
);

  cmd_t                cq_mem_q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                push, pop;

  assign req_ready_o = (cnt_q != CQ_CNT_W'(CQ_DEPTH));
  assign push        = req_valid_i && req_ready_o;
  assign pop         = cq_pop_i && (cnt_q != '0);

  assign cq_o.valid = (cnt_q != '0);
  assign cq_o.cmd   = cq_mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the classified command
  always_ff @(posedge clk_i) begin
    if (push) begin
      cq_mem_q[wr_ptr_q] <= req_cmd_i;
    end
  end

endmodule

[design/spq_back.sv]
// Back end of the sorted priority queue: a compare-and-shift cell array that
// runs one command per cycle while no result is held, and registers the result item. Uses spq_pkg.
module spq_back import spq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_chan_t cq_i,
  output logic      cq_pop_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  output rsp_t      rsp_o
);

  logic [DATA_W-1:0]        slot_data_q [CAPACITY];
  logic signed [PRIO_W-1:0] slot_prio_q [CAPACITY];
  logic [DATA_W-1:0]        slot_data_d [CAPACITY];
  logic signed [PRIO_W-1:0] slot_prio_d [CAPACITY];
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CAPACITY-1:0]      ge, ins;
  logic                     full, empty, do_enq, do_deq, exec;
  logic                     rsp_valid_q;
  rsp_t                     rsp_q, rsp_d;

  assign exec     = cq_i.valid && (!rsp_valid_q || rsp_ready_i);
  assign cq_pop_o = exec;
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);
  assign do_enq   = (cq_i.cmd.func == FUNC_ENQ) && !full;
  assign do_deq   = (cq_i.cmd.func == FUNC_DEQ) && !empty;

  // Each occupied cell compares its priority against the new item
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge[i] = (count_q > CNT_W'(i)) && (slot_prio_q[i] >= cq_i.cmd.prio);
    end
    ins[0] = !ge[0];
    for (int i = 1; i < CAPACITY; i++) begin
      ins[i] = !ge[i] && ge[i-1];
    end
  end

  // Next cell contents: keep, take the new item, or shift from a neighbor
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_data_d[i] = slot_data_q[i];
      slot_prio_d[i] = slot_prio_q[i];
      if (do_enq && !ge[i]) begin
        if (ins[i]) begin
          slot_data_d[i] = cq_i.cmd.data;
          slot_prio_d[i] = cq_i.cmd.prio;
        end else if (i > 0) begin
          slot_data_d[i] = slot_data_q[i-1];
          slot_prio_d[i] = slot_prio_q[i-1];
        end
      end else if (do_deq && (i < CAPACITY - 1)) begin
        slot_data_d[i] = slot_data_q[i+1];
        slot_prio_d[i] = slot_prio_q[i+1];
      end
    end
  end

  // Count update and result assembly
  always_comb begin
    count_d = count_q;
    if (do_enq) begin
      count_d = count_q + 1'b1;
    end else if (do_deq) begin
      count_d = count_q - 1'b1;
    end

    rsp_d              = '0;
    rsp_d.status       = ST_OK;
    if ((cq_i.cmd.func == FUNC_ENQ) && full) begin
      rsp_d.status = ST_FULL;
    end else if ((cq_i.cmd.func == FUNC_DEQ) && empty) begin
      rsp_d.status = ST_EMPTY;
    end
    if (do_deq) begin
      rsp_d.removed_data = slot_data_q[0];
      rsp_d.removed_prio = slot_prio_q[0];
    end
    rsp_d.head_valid = (count_d != '0);
    if (count_d != '0) begin
      rsp_d.head_data = slot_data_d[0];
      rsp_d.head_prio = slot_prio_d[0];
    end
    rsp_d.occupancy = OCC_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (exec) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Cell array and result payload hold no reset
  always_ff @(posedge clk_i) begin
    if (exec) begin
      slot_data_q <= slot_data_d;
      slot_prio_q <= slot_prio_d;
      rsp_q       <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

[design/sorted_priority_queue.sv]
// Sorted priority queue, 16 entries, highest priority first, FIFO among equals.
// A request item is first written into the command queue; the back end then
// executes it and registers the result item; a held result delays this.
// Throughput: one item per cycle while no result is held; the cell array inserts or removes by compare and shift.
// Reset clears the item count and all valid flags; cell contents are not reset.
// Depends on spq_pkg, spq_intf, spq_front and spq_back.
module sorted_priority_queue import spq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  spq_req_if.sink      req_i,
  spq_rsp_if.source    rsp_o
);

  cmd_t      req_cmd;
  cmd_chan_t cq;
  logic      cq_pop;
  logic      rsp_valid;
  rsp_t      rsp;

  // Classify the request into a command
  assign req_cmd.func = req_i.func ? FUNC_DEQ : FUNC_ENQ;
  assign req_cmd.data = req_i.item_data;
  assign req_cmd.prio = req_i.item_priority;

  spq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_cmd_i   (req_cmd),
    .cq_o        (cq),
    .cq_pop_i    (cq_pop)
  );

  spq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cq_i        (cq),
    .cq_pop_o    (cq_pop),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp)
  );

  // Drive the response channel
  assign rsp_o.valid            = rsp_valid;
  assign rsp_o.status           = rsp.status;
  assign rsp_o.removed_data     = rsp.removed_data;
  assign rsp_o.removed_priority = rsp.removed_prio;
  assign rsp_o.head_valid       = rsp.head_valid;
  assign rsp_o.head_data        = rsp.head_data;
  assign rsp_o.head_priority    = rsp.head_prio;
  assign rsp_o.occupancy        = rsp.occupancy;

endmodule

[design/spq_checker.sv]
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
module spq_props import spq_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     rsp_valid_i,
  input logic                     rsp_ready_i,
  input logic [STAT_W-1:0]        status_i,
  input logic                     head_valid_i,
  input logic [DATA_W-1:0]        head_data_i,
  input logic signed [PRIO_W-1:0] head_priority_i,
  input logic [OCC_W-1:0]         occupancy_i
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(occupancy_i)
      && $stable(status_i))
    else $error("result changed while stalled");

  // Head flag tracks occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (head_valid_i == (occupancy_i != '0)))
    else $error("head_valid disagrees with occupancy");

  // Empty queue shows a zero head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !head_valid_i |-> (head_data_i == '0) && (head_priority_i == '0))
    else $error("empty queue shows a head");

  // Full rejection only at capacity, empty flag only at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_FULL) |-> (occupancy_i == OCC_W'(CAPACITY)))
    else $error("full status below capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_EMPTY) |-> (occupancy_i == '0))
    else $error("empty status with stored items");

endmodule

bind sorted_priority_queue spq_props u_spq_props (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .status_i        (rsp_o.status),
  .head_valid_i    (rsp_o.head_valid),
  .head_data_i     (rsp_o.head_data),
  .head_priority_i (rsp_o.head_priority),
  .occupancy_i     (rsp_o.occupancy)
);

[tb/spq_checker.sv]
// Result checker for the sorted priority queue: watches the request and response
// channels, keeps its own sorted copy of the queue and compares every result item.
// Depends on spq_pkg and spq_intf.
`timescale 1ns / 1ps

module spq_checker import spq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  spq_req_if   req_mon,
  spq_rsp_if   rsp_mon,
  output int   fail_cnt_o,
  output int   pending_o
);

  // Shadow copy of the stored items, highest priority in slot 0
  logic [DATA_W-1:0]        slot_d [CAPACITY];
  logic signed [PRIO_W-1:0] slot_p [CAPACITY];
  int                       n_stored = 0;

  rsp_t owed_results[$];
  int   mismatch_cnt = 0;

  // Apply one operation to the shadow queue and return the result it owes
  function automatic rsp_t apply_queue_op(func_e f, logic [DATA_W-1:0] d,
                                          logic signed [PRIO_W-1:0] p);
    rsp_t r;
    int   pos;
    int   k;
    r        = '0;
    r.status = ST_OK;
    if (f == FUNC_ENQ) begin
      if (n_stored >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // Insert after every item of greater or equal priority
        pos = 0;
        while (pos < n_stored && slot_p[pos] >= p) pos++;
        for (k = n_stored; k > pos; k--) begin
          slot_d[k] = slot_d[k-1];
          slot_p[k] = slot_p[k-1];
        end
        slot_d[pos] = d;
        slot_p[pos] = p;
        n_stored++;
      end
    end else if (n_stored == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // Pop the head and close the gap
      r.removed_data = slot_d[0];
      r.removed_prio = slot_p[0];
      for (k = 0; k + 1 < n_stored; k++) begin
        slot_d[k] = slot_d[k+1];
        slot_p[k] = slot_p[k+1];
      end
      n_stored--;
    end
    if (n_stored > 0) begin
      r.head_valid = 1'b1;
      r.head_data  = slot_d[0];
      r.head_prio  = slot_p[0];
    end
    r.occupancy = OCC_W'(n_stored);
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Record accepted operations, then match accepted results in order
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (req_mon.valid && req_mon.ready) begin
        owed_results.push_back(apply_queue_op(func_e'(req_mon.func), req_mon.item_data,
                                              req_mon.item_priority));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (owed_results.size() == 0) begin
          $error("result item with no operation outstanding");
          mismatch_cnt++;
        end else begin
          want = owed_results.pop_front();
          check_field("status", want.status, rsp_mon.status);
          check_field("removed_data", want.removed_data, rsp_mon.removed_data);
          check_field("removed_priority", want.removed_prio, rsp_mon.removed_priority);
          check_field("head_valid", want.head_valid, rsp_mon.head_valid);
          check_field("head_data", want.head_data, rsp_mon.head_data);
          check_field("head_priority", want.head_prio, rsp_mon.head_priority);
          check_field("occupancy", want.occupancy, rsp_mon.occupancy);
        end
      end
      pending_o  <= owed_results.size();
      fail_cnt_o <= mismatch_cnt;
    end
  end

endmodule

[tb/sorted_priority_queue_tb.sv]
// Top of the sorted priority queue testbench: clock, reset, request stimulus and
// response back-pressure; spq_checker does the prediction and comparison.
// Depends on spq_pkg, spq_intf, sorted_priority_queue and spq_checker.
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int ROUNDS     = 6;
  localparam int ROUND_OPS  = 115;
  localparam int LONG_HOLD  = 120;
  localparam int DRAIN_CYC  = 8;

  logic clk_i;
  logic rst_ni;
  int   fail_cnt;
  int   pending;

  // Phase knobs shared by the sender and receiver processes
  bit   req_gaps_on   = 1'b1;
  bit   rsp_stalls_on = 1'b1;
  int   enq_pct       = 50;
  int   hold_asked    = 0;
  int   hold_done     = 0;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  sorted_priority_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  spq_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_mon    (req_if),
    .rsp_mon    (rsp_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Extremes, a narrow band full of ties, or anything
  function automatic logic signed [PRIO_W-1:0] rand_priority();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 16'sh8000;
    if (pick == 1) return 16'sh7FFF;
    if (pick <= 4) return 16'($urandom_range(0, 8) - 4);
    return 16'($urandom);
  endfunction

  // Offer one item, hold it until accepted, then maybe idle
  task automatic issue_op(input func_e f, input logic [DATA_W-1:0] d,
                          input logic signed [PRIO_W-1:0] p);
    int gap;
    req_if.valid         <= 1'b1;
    req_if.func          <= f;
    req_if.item_data     <= d;
    req_if.item_priority <= p;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    gap = req_gaps_on ? gap_cycles() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Lower valid and wait until every owed result has come back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Response back-pressure: random stalls plus long holds on request
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left == 0) begin
        if (hold_done != hold_asked) begin
          hold_done++;
          stall_left = LONG_HOLD;
        end else if (rsp_stalls_on) begin
          stall_left = gap_cycles();
        end
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Request stimulus and verdict
  initial begin
    int    i;
    int    r;
    func_e f;
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.func          = FUNC_ENQ;
    req_if.item_data     = '0;
    req_if.item_priority = '0;
    rsp_if.ready         = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty dequeue, lone extreme item, fill with extremes and ties,
    // rejected enqueue on full, then pull a few from the top
    issue_op(FUNC_DEQ, 8'hA5, 16'sh1234);
    issue_op(FUNC_ENQ, 8'hFF, 16'sh7FFF);
    issue_op(FUNC_DEQ, 8'h00, 16'sh0000);
    for (i = 0; i < CAPACITY; i++) begin
      case (i % 4)
        0: r = -32768;
        1: r = 32767;
        2: r = -5;
        default: r = 0;
      endcase
      issue_op(FUNC_ENQ, {i[3:0], ~i[3:0]}, 16'(r));
    end
    issue_op(FUNC_ENQ, 8'h5A, 16'sh7FFF);
    for (i = 0; i < 6; i++) issue_op(FUNC_DEQ, 8'($urandom), 16'($urandom));

    // Random rounds: fill-biased, drain-biased, balanced
    for (r = 0; r < ROUNDS; r++) begin
      case (r % 3)
        0: enq_pct = 75;
        1: enq_pct = 25;
        default: enq_pct = 50;
      endcase
      req_gaps_on   = (r != 4);
      rsp_stalls_on = (r != 4);
      if (r == 2) begin
        // Starve the output while requests keep coming
        req_gaps_on = 1'b0;
        hold_asked++;
      end
      for (i = 0; i < ROUND_OPS; i++) begin
        f = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
        issue_op(f, 8'($urandom), rand_priority());
      end
      if (r == 3) wait_drained();
    end

    // Drain and decide
    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
